// ===== rtl/core/mlrd_pkg.sv =====
`timescale 1ns / 1ps

package mlrd_pkg;

  // defaults for the top-level parameters
  localparam int MAX_SYMBOLS_DEF = 9;
  localparam int SAMPLE_BITS_DEF = 12;

  // tick counters and register widths
  localparam int CNT_BITS     = 16;
  localparam int THR_BITS     = 12;
  localparam int TICK_BITS    = 12;
  localparam int END_BITS     = 13;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DAT_BITS = 13;

  // longest pattern the code table knows
  localparam int PATTERN_MAX_LEN = 5;

  // result queue, power of two
  localparam int OUT_FIFO_DEPTH = 8;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_ON_LEVEL         = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DOT_MIN_TICKS    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DASH_MIN_TICKS   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LETTER_GAP_TICKS = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WORD_GAP_TICKS   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_END_IDLE_TICKS   = 3'd5;

  // reset values of the registers
  localparam logic [THR_BITS-1:0]  RST_ON_LEVEL         = 12'd80;
  localparam logic [TICK_BITS-1:0] RST_DOT_MIN_TICKS    = 12'd5;
  localparam logic [TICK_BITS-1:0] RST_DASH_MIN_TICKS   = 12'd20;
  localparam logic [TICK_BITS-1:0] RST_LETTER_GAP_TICKS = 12'd30;
  localparam logic [TICK_BITS-1:0] RST_WORD_GAP_TICKS   = 12'd70;
  localparam logic [END_BITS-1:0]  RST_END_IDLE_TICKS   = 13'd140;

  // result kinds
  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_SPACE = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // special character codes
  localparam logic [6:0] CHAR_SPACE   = 7'h20;
  localparam logic [6:0] CHAR_UNKNOWN = 7'h3F;
  localparam logic [6:0] CHAR_NONE    = 7'h00;

  typedef struct packed {
    logic [THR_BITS-1:0]  on_level;
    logic [TICK_BITS-1:0] dot_min_ticks;
    logic [TICK_BITS-1:0] dash_min_ticks;
    logic [TICK_BITS-1:0] letter_gap_ticks;
    logic [TICK_BITS-1:0] word_gap_ticks;
    logic [END_BITS-1:0]  end_idle_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] char_code;
    logic       last;
  } res_t;

  // results of one sample, pushed together
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  // pattern lookup: bit i is symbol i, 1 a dash; len 1..5
  function automatic logic [6:0] code_lookup(input logic [2:0] len, input logic [4:0] pat);
    logic [6:0] ch;
    ch = CHAR_UNKNOWN;
    case ({len, pat})
      {3'd2, 5'b00010}: ch = 7'h41; // A
      {3'd4, 5'b00001}: ch = 7'h42; // B
      {3'd4, 5'b00101}: ch = 7'h43; // C
      {3'd3, 5'b00001}: ch = 7'h44; // D
      {3'd1, 5'b00000}: ch = 7'h45; // E
      {3'd4, 5'b00100}: ch = 7'h46; // F
      {3'd3, 5'b00011}: ch = 7'h47; // G
      {3'd4, 5'b00000}: ch = 7'h48; // H
      {3'd2, 5'b00000}: ch = 7'h49; // I
      {3'd4, 5'b01110}: ch = 7'h4A; // J
      {3'd3, 5'b00101}: ch = 7'h4B; // K
      {3'd4, 5'b00010}: ch = 7'h4C; // L
      {3'd2, 5'b00011}: ch = 7'h4D; // M
      {3'd2, 5'b00001}: ch = 7'h4E; // N
      {3'd3, 5'b00111}: ch = 7'h4F; // O
      {3'd4, 5'b00110}: ch = 7'h50; // P
      {3'd4, 5'b01011}: ch = 7'h51; // Q
      {3'd3, 5'b00010}: ch = 7'h52; // R
      {3'd3, 5'b00000}: ch = 7'h53; // S
      {3'd1, 5'b00001}: ch = 7'h54; // T
      {3'd3, 5'b00100}: ch = 7'h55; // U
      {3'd4, 5'b01000}: ch = 7'h56; // V
      {3'd3, 5'b00110}: ch = 7'h57; // W
      {3'd4, 5'b01001}: ch = 7'h58; // X
      {3'd4, 5'b01101}: ch = 7'h59; // Y
      {3'd4, 5'b00011}: ch = 7'h5A; // Z
      {3'd5, 5'b11111}: ch = 7'h30; // 0
      {3'd5, 5'b11110}: ch = 7'h31; // 1
      {3'd5, 5'b11100}: ch = 7'h32; // 2
      {3'd5, 5'b11000}: ch = 7'h33; // 3
      {3'd5, 5'b10000}: ch = 7'h34; // 4
      {3'd5, 5'b00000}: ch = 7'h35; // 5
      {3'd5, 5'b00001}: ch = 7'h36; // 6
      {3'd5, 5'b00011}: ch = 7'h37; // 7
      {3'd5, 5'b00111}: ch = 7'h38; // 8
      {3'd5, 5'b01111}: ch = 7'h39; // 9
      default:          ch = CHAR_UNKNOWN;
    endcase
    return ch;
  endfunction

endpackage

// ===== rtl/core/mlrd_ifs.sv =====
`timescale 1ns / 1ps

interface mlrd_in_if import mlrd_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface mlrd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [6:0] char_code;
  logic       last;

  modport source (output valid, output kind, output char_code, output last, input ready);
  modport sink   (input valid, input kind, input char_code, input last, output ready);
endinterface

// ===== rtl/core/mlrd_cfg_regs.sv =====
`timescale 1ns / 1ps

module mlrd_cfg_regs import mlrd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_DAT_BITS-1:0] cfg_wdata,
  output cfg_t                    cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.on_level         <= RST_ON_LEVEL;
      cfg_r.dot_min_ticks    <= RST_DOT_MIN_TICKS;
      cfg_r.dash_min_ticks   <= RST_DASH_MIN_TICKS;
      cfg_r.letter_gap_ticks <= RST_LETTER_GAP_TICKS;
      cfg_r.word_gap_ticks   <= RST_WORD_GAP_TICKS;
      cfg_r.end_idle_ticks   <= RST_END_IDLE_TICKS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ON_LEVEL:         cfg_r.on_level         <= cfg_wdata[THR_BITS-1:0];
        CFG_DOT_MIN_TICKS:    cfg_r.dot_min_ticks    <= cfg_wdata[TICK_BITS-1:0];
        CFG_DASH_MIN_TICKS:   cfg_r.dash_min_ticks   <= cfg_wdata[TICK_BITS-1:0];
        CFG_LETTER_GAP_TICKS: cfg_r.letter_gap_ticks <= cfg_wdata[TICK_BITS-1:0];
        CFG_WORD_GAP_TICKS:   cfg_r.word_gap_ticks   <= cfg_wdata[TICK_BITS-1:0];
        CFG_END_IDLE_TICKS:   cfg_r.end_idle_ticks   <= cfg_wdata[END_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/mlrd_tracker.sv =====
`timescale 1ns / 1ps

module mlrd_tracker import mlrd_pkg::*; #(
  parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_fire,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  cfg_t                   cfg,
  output logic                   busy,
  output push_t                  push
);

  localparam int CW   = $clog2(MAX_SYMBOLS + 1);
  localparam int CMPW = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;
  localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};

  // input register: light level of the accepted sample
  logic s1_valid_r;
  logic light_r;

  logic                   prev_light_r, prev_light_nxt;
  logic [CNT_BITS-1:0]    pulse_r, pulse_nxt;
  logic [CNT_BITS-1:0]    gap_r, gap_nxt;
  logic [CNT_BITS-1:0]    idle_r, idle_nxt;
  logic [MAX_SYMBOLS-1:0] bits_r, bits_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic                   pend_r, pend_nxt;

  logic [6:0] held_char;

  function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] v);
    return (v == CNT_MAX) ? v : CNT_BITS'(v + 1'b1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      light_r <= CMPW'(in_sample) > CMPW'(cfg.on_level);
    end
  end

  assign busy = s1_valid_r;

  // held pattern, decoded once per tick
  always_comb begin
    if (cnt_r > CW'(PATTERN_MAX_LEN)) begin
      held_char = CHAR_UNKNOWN;
    end else begin
      held_char = code_lookup(3'(cnt_r), bits_r[PATTERN_MAX_LEN-1:0]);
    end
  end

  always_comb begin
    logic rise;
    logic fall;
    res_t rc;
    rise           = light_r & ~prev_light_r;
    fall           = ~light_r & prev_light_r;
    prev_light_nxt = prev_light_r;
    pulse_nxt      = pulse_r;
    gap_nxt        = gap_r;
    idle_nxt       = idle_r;
    bits_nxt       = bits_r;
    cnt_nxt        = cnt_r;
    pend_nxt       = pend_r;
    push           = '0;
    rc             = '{kind: KIND_CHAR, char_code: held_char, last: 1'b0};
    if (s1_valid_r) begin
      pulse_nxt = sat_inc(pulse_r);
      gap_nxt   = sat_inc(gap_r);
      idle_nxt  = sat_inc(idle_r);

      if (rise) begin
        if (gap_nxt >= CNT_BITS'(cfg.word_gap_ticks)) begin
          if (cnt_r != '0) begin
            push.r0 = rc;
            push.r1 = '{kind: KIND_SPACE, char_code: CHAR_SPACE, last: 1'b0};
            push.n  = 2'd2;
          end else begin
            push.r0 = '{kind: KIND_SPACE, char_code: CHAR_SPACE, last: 1'b0};
            push.n  = 2'd1;
          end
          pend_nxt = 1'b1;
          bits_nxt = '0;
          cnt_nxt  = '0;
        end else if (gap_nxt >= CNT_BITS'(cfg.letter_gap_ticks) && cnt_r != '0) begin
          push.r0  = rc;
          push.n   = 2'd1;
          pend_nxt = 1'b1;
          bits_nxt = '0;
          cnt_nxt  = '0;
        end
        pulse_nxt = '0;
        idle_nxt  = '0;
      end else if (fall) begin
        if ((pulse_nxt >= CNT_BITS'(cfg.dash_min_ticks)) && (cnt_r < CW'(MAX_SYMBOLS))) begin
          bits_nxt = bits_r | (MAX_SYMBOLS'(1) << cnt_r);
          cnt_nxt  = CW'(cnt_r + 1'b1);
        end else if ((pulse_nxt >= CNT_BITS'(cfg.dot_min_ticks))
                     && (cnt_r < CW'(MAX_SYMBOLS))) begin
          cnt_nxt = CW'(cnt_r + 1'b1);
        end
        gap_nxt  = '0;
        idle_nxt = '0;
      end

      // idle timeout decode, never on an edge tick (idle was just cleared)
      if (!light_r && cnt_nxt != '0 && idle_nxt > CNT_BITS'(cfg.letter_gap_ticks)) begin
        push.r0  = rc;
        push.n   = 2'd1;
        pend_nxt = 1'b1;
        bits_nxt = '0;
        cnt_nxt  = '0;
        idle_nxt = '0;
      end

      if (!light_r && pend_nxt && idle_nxt > CNT_BITS'(cfg.end_idle_ticks)) begin
        push.r0  = '{kind: KIND_END, char_code: CHAR_NONE, last: 1'b0};
        push.n   = 2'd1;
        pend_nxt = 1'b0;
      end

      if (push.n == 2'd2) begin
        push.r1.last = 1'b1;
      end else begin
        push.r0.last = 1'b1;
      end
      prev_light_nxt = light_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_light_r <= 1'b0;
      pulse_r      <= '0;
      gap_r        <= '0;
      idle_r       <= '0;
      bits_r       <= '0;
      cnt_r        <= '0;
      pend_r       <= 1'b0;
    end else begin
      prev_light_r <= prev_light_nxt;
      pulse_r      <= pulse_nxt;
      gap_r        <= gap_nxt;
      idle_r       <= idle_nxt;
      bits_r       <= bits_nxt;
      cnt_r        <= cnt_nxt;
      pend_r       <= pend_nxt;
    end
  end

  a_two_is_char_space: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n == 2'd2) |-> (push.r0.kind == KIND_CHAR && push.r1.kind == KIND_SPACE))
    else $error("two results that are not a character and a space");

  a_end_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 2'd0 && push.r0.kind == KIND_END) |-> (push.n == 2'd1 && !pend_nxt))
    else $error("end marker not alone or message still pending");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_SYMBOLS))
    else $error("symbol count above limit");

endmodule

// ===== rtl/core/mlrd_res_fifo.sv =====
`timescale 1ns / 1ps

module mlrd_res_fifo import mlrd_pkg::*; #(
  parameter int DEPTH = OUT_FIFO_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  push_t                      push,
  output logic [$clog2(DEPTH+1)-1:0] level,
  mlrd_out_if.source                 out_ch
);

  localparam int PW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);

  res_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [LW-1:0] level_r;
  logic          pop;
  res_t          head;

  assign pop  = out_ch.valid & out_ch.ready;
  assign head = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem_r[PW'(wr_ptr_r + 1'b1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= PW'(wr_ptr_r + push.n);
      rd_ptr_r <= PW'(rd_ptr_r + pop);
      level_r  <= LW'(level_r + push.n - pop);
    end
  end

  assign level            = level_r;
  assign out_ch.valid     = (level_r != '0);
  assign out_ch.kind      = head.kind;
  assign out_ch.char_code = head.char_code;
  assign out_ch.last      = head.last;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    ((LW + 1)'(level_r) + (LW + 1)'(push.n)) <= (LW + 1)'(DEPTH))
    else $error("result queue overflow");

  a_level_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (level_r != '0 && push.n == 2'd0 && !pop) |=> (level_r == $past(level_r)))
    else $error("queue level moved without push or pop");

endmodule

// ===== rtl/core/morse_light_receiver_decoder.sv =====
`timescale 1ns / 1ps

// channel   | dir | handshake           | payload
// ----------+-----+---------------------+-----------------------------------
// in_ch     | in  | valid / ready       | sample
// out_ch    | out | valid / ready       | kind, char_code, last
// cfg_*     | in  | cfg_we, no wait     | cfg_index, cfg_wdata
//
// a sample is taken every cycle that in_ch.valid and in_ch.ready are high; its light
// level is registered, and the tracker update and result push follow in the next cycle
// results drain one a cycle while out_ch.ready is high, through an eight-entry queue;
// in_ch.ready drops only while the queue cannot hold two results each for any sample
// in flight and for the one on offer, so with out_ch.ready held high the input never stalls
// reset (rst_n low, synchronous) loads the register defaults and clears all
// tracking state and the queue; no clearing pass

module morse_light_receiver_decoder import mlrd_pkg::*; #(
  parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  mlrd_in_if.sink                 in_ch,
  mlrd_out_if.source              out_ch,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_DAT_BITS-1:0] cfg_wdata
);

  localparam int LW = $clog2(OUT_FIFO_DEPTH + 1);
  localparam int RW = LW + 1;

  cfg_t          cfg;
  push_t         push;
  logic          busy;
  logic          in_fire;
  logic [LW-1:0] level;
  logic [RW-1:0] need;

  // live register set
  mlrd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // worst-case queue need: stored items, two for any sample in flight, two for this one
  assign need        = RW'(level) + (busy ? RW'(4) : RW'(2));
  assign in_ch.ready = (need <= RW'(OUT_FIFO_DEPTH));
  assign in_fire     = in_ch.valid & in_ch.ready;

  // light level register, edge timing, symbol store and decode
  mlrd_tracker #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_sample (in_ch.sample),
    .cfg       (cfg),
    .busy      (busy),
    .push      (push)
  );

  // result queue, doubles as the output register
  mlrd_res_fifo #(
    .DEPTH (OUT_FIFO_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .level  (level),
    .out_ch (out_ch)
  );

endmodule
